// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/ssd_pkg.sv =====
// Types, codes and helper functions of the scaled saturating divider.
// No dependencies.
package ssd_pkg;

	localparam int unsigned SCALE_FRAC_BITS_DEF = 16;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned QUO_BITS = 32;

	typedef enum logic [2:0] {
		ET_U8  = 3'd0,
		ET_S8  = 3'd1,
		ET_U16 = 3'd2,
		ET_S16 = 3'd3,
		ET_S32 = 3'd4
	} elem_t;

	typedef enum logic {
		MODE_DIV   = 1'b0,
		MODE_RECIP = 1'b1
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE = 2'd0,
		REG_ETYPE = 2'd1,
		REG_MODE  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic  zero;
		logic  neg;
		logic  ovf;
		elem_t et;
	} ctl_t;

	function automatic elem_t norm_et(logic [2:0] code);
		elem_t et;
		case (code)
			ET_U8:   et = ET_U8;
			ET_S8:   et = ET_S8;
			ET_U16:  et = ET_U16;
			ET_S16:  et = ET_S16;
			default: et = ET_S32;
		endcase
		return et;
	endfunction

	// {sign, magnitude} of the low bits of raw, extended per element type.
	function automatic logic [32:0] extend_mag(logic [31:0] raw, elem_t et);
		logic [31:0] sv;
		case (et)
			ET_U8:   sv = {24'h0, raw[7:0]};
			ET_S8:   sv = {{24{raw[7]}}, raw[7:0]};
			ET_U16:  sv = {16'h0, raw[15:0]};
			ET_S16:  sv = {{16{raw[15]}}, raw[15:0]};
			default: sv = raw;
		endcase
		return {sv[31], sv[31] ? (~sv + 32'd1) : sv};
	endfunction

	function automatic logic [31:0] type_max(elem_t et);
		logic [31:0] m;
		case (et)
			ET_U8:   m = 32'd255;
			ET_S8:   m = 32'd127;
			ET_U16:  m = 32'd65535;
			ET_S16:  m = 32'd32767;
			default: m = 32'h7FFF_FFFF;
		endcase
		return m;
	endfunction

	function automatic logic [31:0] type_min_mag(elem_t et);
		logic [31:0] m;
		case (et)
			ET_S8:   m = 32'd128;
			ET_S16:  m = 32'd32768;
			ET_S32:  m = 32'h8000_0000;
			default: m = 32'd0;
		endcase
		return m;
	endfunction

endpackage

// ===== rtl/ssd_front.sv =====
// Front end: operand extension, scale product and overflow check (three stages).
// Depends on ssd_pkg.
module ssd_front #(
	parameter int unsigned FRAC_BITS = ssd_pkg::SCALE_FRAC_BITS_DEF,
	parameter int unsigned DEN_W = 32 + FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                v_in,
	input  logic [31:0]         numerator,
	input  logic [31:0]         divisor,
	input  logic [31:0]         scale_q,
	input  ssd_pkg::elem_t      et_q,
	input  ssd_pkg::mode_t      mode_q,
	output logic                v_s3,
	output ssd_pkg::ctl_t       ctl_s3,
	output logic [DEN_W-1:0]    rem_s3,
	output logic [DEN_W-1:0]    den_s3,
	output logic [31:0]         low_s3
);
	import ssd_pkg::*;

	localparam logic [31:0] ONE     = 32'(64'd1 << FRAC_BITS);
	localparam logic [31:0] THR_U8  = 32'((64'd1 << FRAC_BITS) + 64'd254) / 32'd255;
	localparam logic [31:0] THR_S8  = 32'((64'd1 << FRAC_BITS) + 64'd126) / 32'd127;
	localparam logic [31:0] THR_U16 = 32'((64'd1 << FRAC_BITS) + 64'd65534) / 32'd65535;
	localparam logic [31:0] THR_S16 = 32'((64'd1 << FRAC_BITS) + 64'd32766) / 32'd32767;
	localparam logic [31:0] THR_S32 = 32'((64'd1 << FRAC_BITS) + 64'h7FFF_FFFE) / 32'h7FFF_FFFF;

	logic [32:0] s_ext, n_ext, d_ext;
	logic [31:0] thr;
	logic        scale_low;
	logic        zero_c;
	logic [DEN_W-1:0] hi_ext;
	logic        ovf_c;

	logic        v_s1;
	ctl_t        ctl_s1;
	logic [31:0] n_s1, s_s1, d_s1;
	logic        v_s2;
	ctl_t        ctl_s2;
	logic [63:0] prod_s2;
	logic [DEN_W-1:0] den_s2;

	always_comb begin
		s_ext = {scale_q[31], scale_q[31] ? (~scale_q + 32'd1) : scale_q};
		d_ext = extend_mag(divisor, et_q);
		n_ext = (mode_q == MODE_RECIP) ? {1'b0, 32'd1} : extend_mag(numerator, et_q);
		case (et_q)
			ET_U8:   thr = THR_U8;
			ET_S8:   thr = THR_S8;
			ET_U16:  thr = THR_U16;
			ET_S16:  thr = THR_S16;
			default: thr = THR_S32;
		endcase
		scale_low = (mode_q == MODE_RECIP) ? (s_ext[31:0] < ONE) : (s_ext[31:0] < thr);
		zero_c    = (s_ext[31:0] == 32'd0) || scale_low || (d_ext[31:0] == 32'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= '{zero: zero_c, neg: s_ext[32] ^ n_ext[32] ^ d_ext[32], ovf: 1'b0,
				et: et_q};
			n_s1 <= n_ext[31:0];
			s_s1 <= s_ext[31:0];
			d_s1 <= d_ext[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2  <= ctl_s1;
			prod_s2 <= 64'(n_s1) * 64'(s_s1);
			den_s2  <= {d_s1, {FRAC_BITS{1'b0}}};
		end
	end

	always_comb begin
		hi_ext = DEN_W'(prod_s2[63:32]);
		ovf_c  = hi_ext >= den_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s3 <= '{zero: ctl_s2.zero, neg: ctl_s2.neg, ovf: ovf_c, et: ctl_s2.et};
			rem_s3 <= ovf_c ? '0 : hi_ext;
			den_s3 <= den_s2;
			low_s3 <= prod_s2[31:0];
		end
	end

endmodule

// ===== rtl/ssd_div_stage.sv =====
// One restoring-division step: one quotient bit per stage.
// Depends on ssd_pkg.
module ssd_div_stage #(
	parameter int unsigned DEN_W = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             v_in,
	input  ssd_pkg::ctl_t    ctl_in,
	input  logic [DEN_W-1:0] rem_in,
	input  logic [DEN_W-1:0] den_in,
	input  logic [31:0]      low_in,
	output logic             v_s1,
	output ssd_pkg::ctl_t    ctl_s1,
	output logic [DEN_W-1:0] rem_s1,
	output logic [DEN_W-1:0] den_s1,
	output logic [31:0]      low_s1
);
	import ssd_pkg::*;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           qbit;

	always_comb begin
		trial = {rem_in, low_in[31]};
		diff  = trial - {1'b0, den_in};
		qbit  = trial >= {1'b0, den_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= ctl_in;
			rem_s1 <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			den_s1 <= den_in;
			low_s1 <= {low_in[30:0], qbit};
		end
	end

endmodule

// ===== rtl/ssd_back.sv =====
// Back end: round to nearest even, then saturate into the output register.
// Depends on ssd_pkg.
module ssd_back #(
	parameter int unsigned DEN_W = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             v_in,
	input  ssd_pkg::ctl_t    ctl_in,
	input  logic [DEN_W-1:0] rem_in,
	input  logic [DEN_W-1:0] den_in,
	input  logic [31:0]      q_in,
	output logic             v_s2,
	output logic [31:0]      res_s2
);
	import ssd_pkg::*;

	logic [DEN_W:0] r2;
	logic           up;
	logic           v_s1;
	ctl_t           ctl_s1;
	logic [32:0]    qr_s1;
	logic [31:0]    lim;
	logic           sat;
	logic [31:0]    mag;
	logic [31:0]    res_c;

	always_comb begin
		r2 = {rem_in, 1'b0};
		up = (r2 > {1'b0, den_in}) || ((r2 == {1'b0, den_in}) && q_in[0]);
	end

	always_comb begin
		lim   = ctl_s1.neg ? type_min_mag(ctl_s1.et) : type_max(ctl_s1.et);
		sat   = ctl_s1.ovf || (qr_s1 > {1'b0, lim});
		mag   = sat ? lim : qr_s1[31:0];
		res_c = ctl_s1.zero ? 32'd0 : (ctl_s1.neg ? (~mag + 32'd1) : mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= ctl_in;
			qr_s1  <= {1'b0, q_in} + 33'(up);
			res_s2 <= res_c;
		end
	end

endmodule

// ===== rtl/scaled_saturating_divide_unit.sv =====
// Top level of the scaled saturating divider: config registers and pipeline.
// Depends on ssd_pkg, ssd_front, ssd_div_stage, ssd_back.
//
//   channel | valid     | stall     | payload
//   input   | in_valid  | in_stall  | numerator, divisor
//   output  | out_valid | out_stall | quotient
//   config  | cfg_wr_en | -         | cfg_index, cfg_data
//
// One item per cycle unless in_stall is high; 32 one-bit divide stages.
// All stages advance together; in_stall is high while a result waits on out_stall.
// Reset clears valid bits and loads scale 1.0, type u8, divide mode.
module scaled_saturating_divide_unit #(
	parameter int unsigned SCALE_FRAC_BITS = ssd_pkg::SCALE_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [31:0]                   numerator,
	input  logic [31:0]                   divisor,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [31:0]                   quotient,
	input  logic                          cfg_wr_en,
	input  logic [ssd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import ssd_pkg::*;

	localparam int unsigned DEN_W = 32 + SCALE_FRAC_BITS;

	logic [31:0] scale_q;
	elem_t       et_q;
	mode_t       mode_q;
	logic        adv;

	logic             v_p   [0:QUO_BITS];
	ctl_t             ctl_p [0:QUO_BITS];
	logic [DEN_W-1:0] rem_p [0:QUO_BITS];
	logic [DEN_W-1:0] den_p [0:QUO_BITS];
	logic [31:0]      low_p [0:QUO_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 32'(64'd1 << SCALE_FRAC_BITS);
			et_q    <= ET_U8;
			mode_q  <= MODE_DIV;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SCALE: scale_q <= cfg_data;
				REG_ETYPE: et_q    <= norm_et(cfg_data[2:0]);
				REG_MODE:  mode_q  <= mode_t'(cfg_data[0]);
				default:   ;
			endcase
		end
	end

	assign in_stall = out_valid && out_stall;
	assign adv      = !in_stall;

	ssd_front #(
		.FRAC_BITS (SCALE_FRAC_BITS),
		.DEN_W     (DEN_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.v_in      (in_valid),
		.numerator (numerator),
		.divisor   (divisor),
		.scale_q   (scale_q),
		.et_q      (et_q),
		.mode_q    (mode_q),
		.v_s3      (v_p[0]),
		.ctl_s3    (ctl_p[0]),
		.rem_s3    (rem_p[0]),
		.den_s3    (den_p[0]),
		.low_s3    (low_p[0])
	);

	for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
		ssd_div_stage #(
			.DEN_W (DEN_W)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.v_in   (v_p[i]),
			.ctl_in (ctl_p[i]),
			.rem_in (rem_p[i]),
			.den_in (den_p[i]),
			.low_in (low_p[i]),
			.v_s1   (v_p[i+1]),
			.ctl_s1 (ctl_p[i+1]),
			.rem_s1 (rem_p[i+1]),
			.den_s1 (den_p[i+1]),
			.low_s1 (low_p[i+1])
		);
	end

	ssd_back #(
		.DEN_W (DEN_W)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.v_in   (v_p[QUO_BITS]),
		.ctl_in (ctl_p[QUO_BITS]),
		.rem_in (rem_p[QUO_BITS]),
		.den_in (den_p[QUO_BITS]),
		.q_in   (low_p[QUO_BITS]),
		.v_s2   (out_valid),
		.res_s2 (quotient)
	);

endmodule

// ===== rtl/ssd_checker.sv =====
// Port-level checks of the scaled saturating divider, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ssd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] quotient
);

	`ASSERT_IMPL(a_stall_only_backpressure, clk, arst_n, in_stall, out_valid && out_stall)
	`ASSERT_IMPL(a_stall_when_blocked, clk, arst_n, out_valid && out_stall, in_stall)
	`ASSERT_IMPL(a_free_when_empty, clk, arst_n, !out_valid, !in_stall)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(quotient))

endmodule

bind scaled_saturating_divide_unit ssd_checker u_ssd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.quotient  (quotient)
);

// ===== dv/scaled_saturating_divide_unit_test.sv =====
// Self-checking testbench for scaled_saturating_divide_unit: a random-idling driver and monitor,
// with a predictor of the rounded, saturated quotient computed in 128-bit integer arithmetic.
// Depends on ssd_pkg and the scaled_saturating_divide_unit RTL.
module scaled_saturating_divide_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ssd_pkg::*;

	localparam int FRAC = 16;
	localparam int LAT = 37;
	localparam int WATCH_LIMIT = 20000;

	typedef struct {
		logic [31:0] num;
		logic [31:0] den;
	} operand_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] numerator = '0;
	logic [31:0] divisor = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] quotient;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_SCALE;
	logic [31:0] cfg_data = '0;

	operand_t pending_q[$];
	logic [31:0] quotient_q[$];
	logic [31:0] scale_reg;
	logic [2:0] etype_reg;
	mode_t mode_reg;
	int errors = 0;
	int idle_watch = 0;
	bit steady = 1'b0;
	bit in_flag;

	scaled_saturating_divide_unit u_top (.*);

	always #6 clk = ~clk;

	function automatic void split_value(logic [31:0] raw, logic [2:0] et,
			output bit neg, output longint unsigned mag);
		logic [31:0] v;
		case (et)
			ET_U8: v = {24'h0, raw[7:0]};
			ET_S8: v = {{24{raw[7]}}, raw[7:0]};
			ET_U16: v = {16'h0, raw[15:0]};
			ET_S16: v = {{16{raw[15]}}, raw[15:0]};
			default: v = raw;
		endcase
		neg = v[31];
		mag = neg ? 64'h1_0000_0000 - {32'h0, v} : {32'h0, v};
	endfunction

	function automatic logic [31:0] predict_quotient(operand_t op);
		logic [2:0] et;
		bit sneg, nneg, dneg, neg;
		longint unsigned smag, nmag, dmag, tmax, tmin;
		logic [127:0] num, dv, q, r;
		et = (etype_reg > 3'd4) ? 3'd4 : etype_reg;
		case (et)
			ET_U8: begin tmax = 255; tmin = 0; end
			ET_S8: begin tmax = 127; tmin = 128; end
			ET_U16: begin tmax = 65535; tmin = 0; end
			ET_S16: begin tmax = 32767; tmin = 32768; end
			default: begin tmax = 64'h7FFF_FFFF; tmin = 64'h8000_0000; end
		endcase
		sneg = scale_reg[31];
		smag = sneg ? 64'h1_0000_0000 - {32'h0, scale_reg} : {32'h0, scale_reg};
		if (smag == 0) return '0;
		if (mode_reg == MODE_DIV && smag * tmax < (64'd1 << FRAC)) return '0;
		if (mode_reg == MODE_RECIP && smag < (64'd1 << FRAC)) return '0;
		split_value(op.den, et, dneg, dmag);
		if (dmag == 0) return '0;
		if (mode_reg == MODE_DIV) split_value(op.num, et, nneg, nmag);
		else begin
			nneg = 1'b0;
			nmag = 1;
		end
		num = nmag * smag;
		dv = {64'h0, dmag} << FRAC;
		neg = nneg ^ sneg ^ dneg;
		q = num / dv;
		r = num % dv;
		if (2 * r > dv || (2 * r == dv && q[0])) q = q + 1;
		if (q == 0) return '0;
		if (neg) begin
			if (q > tmin) q = tmin;
			return 32'(-q);
		end
		if (q > tmax) q = tmax;
		return q[31:0];
	endfunction

	// driver
	always @(posedge clk) begin
		in_flag = ($urandom_range(99) >= 35) || steady;
		if (in_valid && !in_stall) begin
			quotient_q.push_back(predict_quotient(pending_q.pop_front()));
		end
		if (!in_valid || !in_stall) begin
			if (pending_q.size() > 0 && in_flag) begin
				in_valid <= 1'b1;
				numerator <= pending_q[0].num;
				divisor <= pending_q[0].den;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		out_stall <= steady ? 1'b0 : ($urandom_range(99) < 35);
		if (out_valid && !out_stall) begin
			if (quotient_q.size() == 0) begin
				$display("%0t: unexpected quotient %h", $time, quotient);
				errors++;
			end else if (quotient_q[0] !== quotient) begin
				$display("%0t: quotient expected %h actual %h", $time, quotient_q[0], quotient);
				errors++;
				void'(quotient_q.pop_front());
			end else begin
				void'(quotient_q.pop_front());
			end
		end
		if ((out_valid && !out_stall) || (in_valid && !in_stall))
			idle_watch <= 0;
		else
			idle_watch <= idle_watch + 1;
		if (idle_watch > WATCH_LIMIT) begin
			$display("scaled_saturating_divide_unit_test failed");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_SCALE: scale_reg = val;
			REG_ETYPE: etype_reg = val[2:0];
			default: mode_reg = mode_t'(val[0]);
		endcase
	endtask

	task automatic drain;
		while (pending_q.size() > 0 || quotient_q.size() > 0 || in_valid) @(posedge clk);
		repeat (LAT + 4) @(posedge clk);
	endtask

	task automatic push_item(logic [31:0] n, logic [31:0] d);
		operand_t op;
		op.num = n;
		op.den = d;
		pending_q.push_back(op);
	endtask

	function automatic logic [31:0] rand_field();
		case ($urandom_range(5))
			0: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			1: return 32'($urandom_range(3)) - 32'd1;
			2: return $urandom_range(255);
			3: return {{16{1'b0}}, 16'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_scale();
		case ($urandom_range(6))
			0: return 32'h0001_0000;
			1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			2: return 32'($urandom_range(2048));
			3: return -32'($urandom_range(1 << 20));
			4: return 32'($urandom_range(1 << 22));
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [31:0] edge_vals[8];
		scale_reg = 32'h0001_0000;
		etype_reg = ET_U8;
		mode_reg = MODE_DIV;
		edge_vals = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h80, 32'h7F, 32'hFFFF_8000};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes at reset configuration, then signed types and modes
		for (int i = 0; i < 8; i++) push_item(edge_vals[i], edge_vals[(i + 3) % 8]);
		push_item(32'd5, 32'd2);
		push_item(32'd7, 32'd2);
		drain();
		write_reg(REG_ETYPE, ET_S32);
		write_reg(REG_SCALE, 32'h8000_0000);
		for (int i = 0; i < 6; i++) push_item(edge_vals[i], edge_vals[7 - i]);
		drain();
		write_reg(REG_MODE, MODE_RECIP);
		write_reg(REG_SCALE, 32'h7FFF_FFFF);
		for (int i = 0; i < 5; i++) push_item($urandom, edge_vals[i]);
		drain();
		write_reg(REG_SCALE, 32'h0000_FFFF);
		push_item(32'd1, 32'd1);
		drain();
		write_reg(REG_ETYPE, 3'd7);
		write_reg(REG_SCALE, 32'h0);
		push_item(32'd9, 32'd3);
		drain();
		// random phases
		for (int ph = 0; ph < 29; ph++) begin
			write_reg(REG_SCALE, rand_scale());
			write_reg(REG_ETYPE, 3'($urandom_range(7)));
			write_reg(REG_MODE, $urandom_range(1));
			steady = (ph == 14);
			for (int i = 0; i < 50; i++) push_item(rand_field(), rand_field());
			drain();
		end
		steady = 1'b0;
		if (errors == 0)
			$display("scaled_saturating_divide_unit_test passed");
		else
			$display("scaled_saturating_divide_unit_test failed");
		$finish;
	end
endmodule
